### hdl/hrsd_pkg.sv
// hrsd_pkg: shared constants, register indexes and controller/datapath command types
// for the high-pass rms strike detector. No dependencies.
package hrsd_pkg;

  // fixed field and arithmetic widths
  localparam int SAMPLE_BITS        = 16;
  localparam int COEF_BITS          = 24;
  localparam int COEF_FRAC_BITS     = 20;
  localparam int GUARD_BITS         = 8;
  localparam int STATE_BITS         = 40;
  localparam int ACC_BITS           = 48;
  localparam int DHALF_BITS         = STATE_BITS / 2;
  localparam int MUL_B_BITS         = DHALF_BITS + 1;
  localparam int PROD_BITS          = COEF_BITS + MUL_B_BITS;
  localparam int CNT_BITS           = 32;
  localparam int RMS_BITS           = 16;
  localparam int LEN_REG_BITS       = 4;
  localparam int MIN_BLOCK_LOG2     = 4;
  localparam int MAX_BLOCK_LOG2_DEF = 11;

  // configuration port
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_GAIN = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_S1_A1       = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_S1_A2       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_S2_A1       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_S2_A2       = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REFRACTORY  = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_LEN   = 3'd7;

  // register reset values
  localparam logic [COEF_BITS-1:0]    RST_GAIN       = 24'd1048576;
  localparam logic [RMS_BITS-1:0]     RST_THRESHOLD  = 16'd983;
  localparam logic [15:0]             RST_REFRACTORY = 16'd23;
  localparam logic [LEN_REG_BITS-1:0] RST_BLOCK_LEN  = 4'd11;

  // multiplier operand select
  typedef enum logic [1:0] {
    MUL_GAIN,
    MUL_LO,
    MUL_HI,
    MUL_SQ
  } mul_sel_e;

  // accumulator operation
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_GAIN,
    ACC_SUB_LO,
    ACC_SUB_HI
  } acc_op_e;

  typedef struct packed {
    logic     load_x;
    mul_sel_e mul_sel;
    logic     mul_sec;
    logic     mul_tap;
    acc_op_e  acc_op;
    logic     upd;
    logic     upd_sec;
    logic     sq_acc;
    logic     root_start;
    logic     root_step;
    logic     decide;
  } hrsd_cmd_t;

  typedef struct packed {
    logic blk_end;
    logic root_done;
    logic hit;
    logic out_busy;
  } hrsd_stat_t;

endpackage

### hdl/hrsd_stream_if.sv
// hrsd_stream_if: valid/ready channel interfaces for sample items and strike event items.
// Depends on hrsd_pkg.
interface hrsd_in_if;
  import hrsd_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface hrsd_out_if;
  import hrsd_pkg::*;
  logic                valid;
  logic                ready;
  logic [CNT_BITS-1:0] strike_no;
  logic [CNT_BITS-1:0] block_index;
  logic [RMS_BITS-1:0] rms;

  modport source (output valid, output strike_no, output block_index, output rms, input ready);
  modport sink   (input valid, input strike_no, input block_index, input rms, output ready);
endinterface

### hdl/hrsd_datapath.sv
// hrsd_datapath: configuration registers, shared multiplier, biquad accumulator,
// energy sum, bit-serial square root and event registers. Depends on hrsd_pkg.
module hrsd_datapath #(
  parameter int MaxBlockLog2 = hrsd_pkg::MAX_BLOCK_LOG2_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [hrsd_pkg::CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [hrsd_pkg::CFG_DATA_BITS-1:0]      cfg_data_i,
  input  logic signed [hrsd_pkg::SAMPLE_BITS-1:0] sample_i,
  input  hrsd_pkg::hrsd_cmd_t                     cmd_i,
  output hrsd_pkg::hrsd_stat_t                    stat_o,
  input  logic                                    out_ready_i,
  output logic                                    out_valid_o,
  output logic [hrsd_pkg::CNT_BITS-1:0]           strike_no_o,
  output logic [hrsd_pkg::CNT_BITS-1:0]           block_index_o,
  output logic [hrsd_pkg::RMS_BITS-1:0]           rms_o
);
  import hrsd_pkg::*;

  localparam int CntW   = MaxBlockLog2 + 1;
  localparam int EnW    = 2 * SAMPLE_BITS - 1 + MaxBlockLog2;
  localparam int LenW   = $clog2(MaxBlockLog2 + 1);
  localparam int TopBit = ((EnW - 1) / 2) * 2;

  // saturate accumulator value to the filter state width
  function automatic logic signed [STATE_BITS-1:0] sat_state(
    input logic signed [ACC_BITS-1:0] v
  );
    logic signed [ACC_BITS-1:0] hi;
    logic signed [ACC_BITS-1:0] lo;
    hi = ACC_BITS'({1'b0, {(STATE_BITS-1){1'b1}}});
    lo = ~hi;
    if (v > hi) return hi[STATE_BITS-1:0];
    if (v < lo) return lo[STATE_BITS-1:0];
    return v[STATE_BITS-1:0];
  endfunction

  // saturate to the sample width
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [STATE_BITS:0] v
  );
    logic signed [STATE_BITS:0] hi;
    logic signed [STATE_BITS:0] lo;
    hi = (STATE_BITS+1)'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    lo = ~hi;
    if (v > hi) return hi[SAMPLE_BITS-1:0];
    if (v < lo) return lo[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1:0];
  endfunction

  logic signed [COEF_BITS-1:0] gain_q, s1a1_q, s1a2_q, s2a1_q, s2a2_q;
  logic [RMS_BITS-1:0]         thr_q;
  logic [15:0]                 refr_q;
  logic [LEN_REG_BITS-1:0]     blen_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= RST_GAIN;
      s1a1_q <= '0;
      s1a2_q <= '0;
      s2a1_q <= '0;
      s2a2_q <= '0;
      thr_q  <= RST_THRESHOLD;
      refr_q <= RST_REFRACTORY;
      blen_q <= RST_BLOCK_LEN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FILTER_GAIN: gain_q <= cfg_data_i;
        CFG_S1_A1:       s1a1_q <= cfg_data_i;
        CFG_S1_A2:       s1a2_q <= cfg_data_i;
        CFG_S2_A1:       s2a1_q <= cfg_data_i;
        CFG_S2_A2:       s2a2_q <= cfg_data_i;
        CFG_THRESHOLD:   thr_q  <= cfg_data_i[RMS_BITS-1:0];
        CFG_REFRACTORY:  refr_q <= cfg_data_i[15:0];
        CFG_BLOCK_LEN:   blen_q <= cfg_data_i[LEN_REG_BITS-1:0];
      endcase
    end
  end

  logic signed [SAMPLE_BITS-1:0] x_q, y_q;
  logic signed [STATE_BITS-1:0]  s1d0_q, s1d1_q, s2d0_q, s2d1_q;
  logic signed [ACC_BITS-1:0]    acc_q, acc_d;
  logic signed [PROD_BITS-1:0]   prod_q;
  logic signed [COEF_BITS-1:0]   mul_a, coef;
  logic signed [MUL_B_BITS-1:0]  mul_b;
  logic signed [STATE_BITS-1:0]  dsel, uds0, uds1, wnew, ynew;
  logic signed [STATE_BITS+2:0]  yfull;
  logic signed [STATE_BITS:0]    yrnd;
  logic signed [SAMPLE_BITS-1:0] yout;
  logic signed [PROD_BITS:0]     gsum, lsum;

  // multiplier operand select
  always_comb begin
    coef = cmd_i.mul_sec ? (cmd_i.mul_tap ? s2a2_q : s2a1_q)
                         : (cmd_i.mul_tap ? s1a2_q : s1a1_q);
    dsel = cmd_i.mul_sec ? (cmd_i.mul_tap ? s2d1_q : s2d0_q)
                         : (cmd_i.mul_tap ? s1d1_q : s1d0_q);
    unique case (cmd_i.mul_sel)
      MUL_GAIN: begin
        mul_a = gain_q;
        mul_b = MUL_B_BITS'(x_q);
      end
      MUL_LO: begin
        mul_a = coef;
        mul_b = {1'b0, dsel[DHALF_BITS-1:0]};
      end
      MUL_HI: begin
        mul_a = coef;
        mul_b = MUL_B_BITS'($signed(dsel[STATE_BITS-1:DHALF_BITS]));
      end
      default: begin
        mul_a = COEF_BITS'(y_q);
        mul_b = MUL_B_BITS'(y_q);
      end
    endcase
  end

  // section update: new state word, section output, final rounded sample
  always_comb begin
    uds0  = cmd_i.upd_sec ? s2d0_q : s1d0_q;
    uds1  = cmd_i.upd_sec ? s2d1_q : s1d1_q;
    wnew  = sat_state(acc_q);
    yfull = (STATE_BITS+3)'(wnew) - ((STATE_BITS+3)'(uds0) <<< 1) + (STATE_BITS+3)'(uds1);
    ynew  = sat_state(ACC_BITS'(yfull));
    yrnd  = (STATE_BITS+1)'(ynew) + (STATE_BITS+1)'(1 << (GUARD_BITS-1));
    yout  = sat_sample(yrnd >>> GUARD_BITS);
  end

  // accumulator next value
  always_comb begin
    gsum = (PROD_BITS+1)'(prod_q) + (PROD_BITS+1)'(1 << (COEF_FRAC_BITS-GUARD_BITS-1));
    lsum = (PROD_BITS+1)'(prod_q) + (PROD_BITS+1)'(1 << (COEF_FRAC_BITS-1));
    unique case (cmd_i.acc_op)
      ACC_GAIN:   acc_d = ACC_BITS'(gsum >>> (COEF_FRAC_BITS-GUARD_BITS));
      ACC_SUB_LO: acc_d = acc_q - ACC_BITS'(lsum >>> COEF_FRAC_BITS);
      ACC_SUB_HI: acc_d = acc_q - ACC_BITS'(prod_q);
      default:    acc_d = acc_q;
    endcase
    if (cmd_i.upd) acc_d = ACC_BITS'(ynew);
  end

  // filter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1d0_q <= '0;
      s1d1_q <= '0;
      s2d0_q <= '0;
      s2d1_q <= '0;
    end else if (cmd_i.upd) begin
      if (cmd_i.upd_sec) begin
        s2d1_q <= s2d0_q;
        s2d0_q <= wnew;
      end else begin
        s1d1_q <= s1d0_q;
        s1d0_q <= wnew;
      end
    end
  end

  // payload registers of the filter path
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    acc_q  <= acc_d;
    if (cmd_i.load_x) x_q <= sample_i;
    if (cmd_i.upd && cmd_i.upd_sec) y_q <= yout;
  end

  // block length clamp and end of block
  logic [LenW-1:0]   lcl;
  logic [EnW-1:0]    energy_q, mean;
  logic [CntW-1:0]   count_q;
  always_comb begin
    if (blen_q < LEN_REG_BITS'(MIN_BLOCK_LOG2)) lcl = LenW'(MIN_BLOCK_LOG2);
    else if (32'(blen_q) > MaxBlockLog2)        lcl = LenW'(MaxBlockLog2);
    else                                        lcl = LenW'(blen_q);
    mean = energy_q >> lcl;
  end

  // square root, one result bit per cycle
  logic [EnW-1:0] rem_q, res_q, bit_q;
  logic [EnW:0]   trial;
  logic [RMS_BITS-1:0] rms;
  assign trial = (EnW+1)'(res_q) + (EnW+1)'(bit_q);
  assign rms   = (|res_q[EnW-1:RMS_BITS]) ? '1 : res_q[RMS_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (cmd_i.root_start) begin
      bit_q <= EnW'(1) << TopBit;
    end else if (cmd_i.root_step) begin
      bit_q <= bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_start) begin
      rem_q <= mean;
      res_q <= '0;
    end else if (cmd_i.root_step) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_q <= rem_q - trial[EnW-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  // strike decision
  logic [CNT_BITS-1:0] blk_q, last_q, ev_q;
  logic                seen_q, out_valid_q, hit;
  assign hit = (!seen_q || (blk_q - last_q) >= CNT_BITS'(refr_q)) && (rms > thr_q);

  // energy, counters and event state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q    <= '0;
      count_q     <= '0;
      blk_q       <= '0;
      last_q      <= '0;
      ev_q        <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.decide && hit) out_valid_q <= 1'b1;
      else if (out_ready_i)    out_valid_q <= 1'b0;
      if (cmd_i.sq_acc) begin
        energy_q <= energy_q + EnW'(prod_q[2*SAMPLE_BITS-1:0]);
        count_q  <= count_q + 1'b1;
      end
      if (cmd_i.decide) begin
        energy_q <= '0;
        count_q  <= '0;
        blk_q    <= blk_q + 1'b1;
        if (hit) begin
          seen_q <= 1'b1;
          last_q <= blk_q;
          ev_q   <= ev_q + 1'b1;
        end
      end
    end
  end

  // event payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide && hit) begin
      strike_no_o   <= ev_q + 1'b1;
      block_index_o <= blk_q;
      rms_o         <= rms;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stat_o.blk_end   = count_q >= (CntW'(1) << lcl);
  assign stat_o.root_done = (bit_q == '0);
  assign stat_o.hit       = hit;
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

endmodule

### hdl/hrsd_ctrl.sv
// hrsd_ctrl: sequencer that steps the datapath through gain, two biquad sections,
// squaring, block end check, square root and event decision. Depends on hrsd_pkg.
module hrsd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hrsd_pkg::hrsd_stat_t stat_i,
  output hrsd_pkg::hrsd_cmd_t  cmd_o
);
  import hrsd_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_GAIN   = 13'b0000000000010,
    ST_LOAD   = 13'b0000000000100,
    ST_T0     = 13'b0000000001000,
    ST_T1     = 13'b0000000010000,
    ST_T2     = 13'b0000000100000,
    ST_T3     = 13'b0000001000000,
    ST_UPD    = 13'b0000010000000,
    ST_SQ     = 13'b0000100000000,
    ST_ACCUM  = 13'b0001000000000,
    ST_CHECK  = 13'b0010000000000,
    ST_ROOT   = 13'b0100000000000,
    ST_DECIDE = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   sec_q, sec_d;

  // next state and datapath commands
  always_comb begin
    state_d    = state_q;
    sec_d      = sec_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.mul_sec = sec_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_x = 1'b1;
          state_d      = ST_GAIN;
        end
      end
      ST_GAIN: begin
        cmd_o.mul_sel = MUL_GAIN;
        state_d       = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.acc_op  = ACC_GAIN;
        cmd_o.mul_sel = MUL_LO;
        cmd_o.mul_sec = 1'b0;
        sec_d         = 1'b0;
        state_d       = ST_T0;
      end
      ST_T0: begin
        cmd_o.acc_op  = ACC_SUB_LO;
        cmd_o.mul_sel = MUL_HI;
        state_d       = ST_T1;
      end
      ST_T1: begin
        cmd_o.acc_op  = ACC_SUB_HI;
        cmd_o.mul_sel = MUL_LO;
        cmd_o.mul_tap = 1'b1;
        state_d       = ST_T2;
      end
      ST_T2: begin
        cmd_o.acc_op  = ACC_SUB_LO;
        cmd_o.mul_sel = MUL_HI;
        cmd_o.mul_tap = 1'b1;
        state_d       = ST_T3;
      end
      ST_T3: begin
        cmd_o.acc_op = ACC_SUB_HI;
        state_d      = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd     = 1'b1;
        cmd_o.upd_sec = sec_q;
        if (!sec_q) begin
          // second section starts right away
          cmd_o.mul_sel = MUL_LO;
          cmd_o.mul_sec = 1'b1;
          sec_d         = 1'b1;
          state_d       = ST_T0;
        end else begin
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.mul_sel = MUL_SQ;
        state_d       = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd_o.sq_acc = 1'b1;
        state_d      = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat_i.blk_end) begin
          cmd_o.root_start = 1'b1;
          state_d          = ST_ROOT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ROOT: begin
        if (stat_i.root_done) state_d = ST_DECIDE;
        else                  cmd_o.root_step = 1'b1;
      end
      ST_DECIDE: begin
        // hold while a previous event item still waits and this decision is a hit
        if (!(stat_i.hit && stat_i.out_busy)) begin
          cmd_o.decide = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sec_q   <= sec_d;
    end
  end

endmodule

### hdl/highpass_rms_strike_detector_unit.sv
// Strike detector: each sample item passes a two-section high-pass biquad filter
// on one shared 24x21 multiplier, is squared and summed in ten multiplier passes of
// the sequencer; a new sample is taken only once the previous one is done. The last
// sample of a block further runs the bit-serial square root and decision, and an
// event item is emitted when the block rms exceeds the threshold outside the
// refractory distance. A waiting event item does not block new samples; only a
// second event stalls until the first is taken.
// Depends on hrsd_pkg, hrsd_stream_if, hrsd_ctrl and hrsd_datapath.
module highpass_rms_strike_detector_unit #(
  parameter int MaxBlockLog2 = hrsd_pkg::MAX_BLOCK_LOG2_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [hrsd_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [hrsd_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  hrsd_in_if.sink                            in_i,
  hrsd_out_if.source                         out_o
);
  import hrsd_pkg::*;

  hrsd_cmd_t  cmd;
  hrsd_stat_t stat;

  // sequencer
  hrsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // arithmetic and state
  hrsd_datapath #(
    .MaxBlockLog2 (MaxBlockLog2)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .sample_i      (in_i.sample),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .strike_no_o   (out_o.strike_no),
    .block_index_o (out_o.block_index),
    .rms_o         (out_o.rms)
  );

endmodule
